// ===== rtl/core/bda_pkg.sv =====
// shared types, constants and the bcd adjust function for the binary to decimal ascii block
// no dependencies
package bda_pkg;

  localparam int BIN_W   = 32;
  localparam int DIG_W   = 4;
  localparam int DIGITS  = 10;
  localparam int BCD_W   = DIG_W * DIGITS;
  localparam int CHAR_W  = 6;
  localparam int CNT_W   = $clog2(BIN_W + 1);
  localparam int DCNT_W  = $clog2(DIGITS + 1);

  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);
  localparam logic [DIG_W-1:0]  DIG_FIVE   = DIG_W'(5);
  localparam logic [DIG_W-1:0]  DIG_THREE  = DIG_W'(3);

  typedef struct packed {
    logic             done;
    logic [BCD_W-1:0] bcd;
  } conv_out_t;

  // add three to every bcd digit that is five or more
  function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] v);
    logic [BCD_W-1:0] r;
    logic [DIG_W-1:0] d;
    r = v;
    for (int i = 0; i < DIGITS; i++) begin
      d = v[i*DIG_W +: DIG_W];
      if (d >= DIG_FIVE) begin
        r[i*DIG_W +: DIG_W] = d + DIG_THREE;
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/binary_to_decimal_ascii.sv =====
// top level: 32-bit binary to decimal ascii digits, most significant first
// depends on bda_pkg, bda_dabble, bda_emit
//
//   port group                   dir  handshake
//   start / number               in   taken when start && !busy
//   digit_valid / digit_char /   out  one word per cycle while digit_valid,
//   last_digit                        no back pressure
//
// an item passes through the shift-and-adjust steps of the bcd converter, a
// hand-over of the bcd word and a walk over the ten bcd digits; the final digit
// is on the ports in the first cycle with busy low, and no new word is taken
// before that cycle.
// between one and ten digits appear at the end of an item, back to back.
// synchronous reset clears all control state and drops digit_valid.
module binary_to_decimal_ascii (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [bda_pkg::BIN_W-1:0]   number,
  output logic                        busy,
  output logic                        digit_valid,
  output logic [bda_pkg::CHAR_W-1:0]  digit_char,
  output logic                        last_digit
);
  import bda_pkg::*;

  logic      conv_busy;
  logic      emit_active;
  conv_out_t conv;

  bda_dabble u_dabble (
    .clk    (clk),
    .rst    (rst),
    .load   (start && !busy),
    .number (number),
    .busy   (conv_busy),
    .conv   (conv)
  );

  bda_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .conv        (conv),
    .active      (emit_active),
    .digit_valid (digit_valid),
    .digit_char  (digit_char),
    .last_digit  (last_digit)
  );

  assign busy = conv_busy || conv.done || emit_active;

  // once the first digit shows, the rest follow without gaps
  a_contiguous: assert property (@(posedge clk) disable iff (rst)
    digit_valid && !last_digit |=> digit_valid)
    else $error("gap between digits");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after start");

  a_ascii_range: assert property (@(posedge clk) disable iff (rst)
    digit_valid |-> (digit_char >= ASCII_ZERO) && (digit_char <= ASCII_ZERO + CHAR_W'(9)))
    else $error("digit character out of range");

  a_no_digit_converting: assert property (@(posedge clk) disable iff (rst)
    digit_valid |-> !conv_busy)
    else $error("digit shown while converter running");

endmodule

// ===== rtl/core/bda_dabble.sv =====
// bit-serial binary to bcd converter, one input bit per cycle
// depends on bda_pkg
module bda_dabble (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  logic [bda_pkg::BIN_W-1:0] number,
  output logic                   busy,
  output bda_pkg::conv_out_t     conv
);
  import bda_pkg::*;

  logic [BIN_W-1:0] bin;
  logic [BCD_W-1:0] bcd;
  logic [CNT_W-1:0] cnt;
  logic             done;
  logic [BCD_W-1:0] bcd_adj;
  logic [BCD_W-1:0] bcd_next;

  assign bcd_adj  = bcd_adjust(bcd);
  assign bcd_next = {bcd_adj[BCD_W-2:0], bin[BIN_W-1]};
  assign conv     = '{done: done, bcd: bcd};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (load && !busy) begin
        bin  <= number;
        bcd  <= '0;
        cnt  <= CNT_W'(BIN_W);
        busy <= 1'b1;
      end else if (busy) begin
        bcd <= bcd_next;
        bin <= {bin[BIN_W-2:0], 1'b0};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/bda_emit.sv =====
// shifts bcd digits out most significant first as ascii, dropping leading zeros
// depends on bda_pkg
module bda_emit (
  input  logic                        clk,
  input  logic                        rst,
  input  bda_pkg::conv_out_t          conv,
  output logic                        active,
  output logic                        digit_valid,
  output logic [bda_pkg::CHAR_W-1:0]  digit_char,
  output logic                        last_digit
);
  import bda_pkg::*;

  logic [BCD_W-1:0]  sr;
  logic [DCNT_W-1:0] cnt;
  logic              seen;
  logic [DIG_W-1:0]  d;
  logic              final_dig;

  assign d         = sr[BCD_W-1 -: DIG_W];
  assign final_dig = (cnt == DCNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      digit_valid <= 1'b0;
      cnt         <= '0;
      seen        <= 1'b0;
    end else begin
      digit_valid <= 1'b0;
      if (conv.done) begin
        sr     <= conv.bcd;
        cnt    <= DCNT_W'(DIGITS);
        seen   <= 1'b0;
        active <= 1'b1;
      end else if (active) begin
        digit_valid <= seen || (d != '0) || final_dig;
        digit_char  <= ASCII_ZERO + CHAR_W'(d);
        last_digit  <= final_dig;
        sr          <= {sr[BCD_W-DIG_W-1:0], {DIG_W{1'b0}}};
        cnt         <= cnt - DCNT_W'(1);
        seen        <= seen || (d != '0);
        if (final_dig) begin
          active <= 1'b0;
        end
      end
    end
  end

endmodule
